// ===== hdl/sji_pkg.sv =====
// Shared widths, register indexes and the job record for the jitter injector.
`default_nettype none

package sji_pkg;

   localparam int PHASE_W     = 32;
   localparam int AMP_W       = 16;
   localparam int SINE_W      = 16;
   localparam int FRAC_W      = 16;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_INDEX_W = 1;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_PHASE_INCREMENT  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_JITTER_AMPLITUDE = 1'b1;

   // Up to three output words produced by one input sample.
   typedef struct packed {
      logic [1:0] count;
      logic [2:0] bits;
      logic       last;
   } job_type;

endpackage

`default_nettype wire

// ===== hdl/sji_req_if.sv =====
// Input channel: one sampled track bit per word.
`default_nettype none

interface sji_req_if;
   logic valid;
   logic ready;
   logic sample_bit;
   logic end_of_track;

   modport source (output valid, output sample_bit, output end_of_track, input ready);
   modport sink   (input valid, input sample_bit, input end_of_track, output ready);
endinterface

`default_nettype wire

// ===== hdl/sji_rsp_if.sv =====
// Result channel: one re-timed output bit per word.
`default_nettype none

interface sji_rsp_if;
   logic valid;
   logic ready;
   logic out_bit;
   logic out_last;

   modport source (output valid, output out_bit, output out_last, input ready);
   modport sink   (input valid, input out_bit, input out_last, output ready);
endinterface

`default_nettype wire

// ===== hdl/sinusoidal_jitter_injector_core.sv =====
// Top level of the sinusoidal jitter injector: register file, front, job queue and back.
//
//   Channel   Direction  Word                       Handshake
//   req_chan  in         sample_bit, end_of_track   valid / ready
//   rsp_chan  out        out_bit, out_last          valid / ready
//   csr_*     in         index, 32-bit data         write enable only
//
// One sample is taken every cycle while the four-entry job queue has room.
// A sample's words pass stages s1 and s2, the job queue and the output register.
// The back sends one word per ready cycle; samples giving two or three words fill the queue.
// The sine table is constant logic, so reset needs no clearing pass.
// A stall on rsp_chan backs up into the queue and then holds req_chan ready low.
`default_nettype none

module sinusoidal_jitter_injector_core import sji_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   sji_req_if.sink                     req_chan,
   sji_rsp_if.source                   rsp_chan,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [PHASE_W-1:0] phase_increment_ff, phase_increment_in;
   logic [AMP_W-1:0]   jitter_amplitude_ff, jitter_amplitude_in;

   logic    queue_ready_w;
   logic    job_push_w;
   job_type job_data_w;
   logic    head_valid_w;
   job_type head_data_w;
   logic    pop_w;

   always_comb begin
      phase_increment_in  = phase_increment_ff;
      jitter_amplitude_in = jitter_amplitude_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_PHASE_INCREMENT:  phase_increment_in  = csr_wdata[PHASE_W-1:0];
            CSR_JITTER_AMPLITUDE: jitter_amplitude_in = csr_wdata[AMP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_increment_ff  <= '0;
         jitter_amplitude_ff <= '0;
      end else begin
         phase_increment_ff  <= phase_increment_in;
         jitter_amplitude_ff <= jitter_amplitude_in;
      end
   end

   sji_front #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .phase_increment  (phase_increment_ff),
      .jitter_amplitude (jitter_amplitude_ff),
      .queue_ready      (queue_ready_w),
      .job_push         (job_push_w),
      .job_data         (job_data_w)
   );

   sji_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push_w),
      .push_data  (job_data_w),
      .push_ready (queue_ready_w),
      .pop        (pop_w),
      .head_valid (head_valid_w),
      .head_data  (head_data_w)
   );

   sji_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid_w),
      .head_data  (head_data_w),
      .pop        (pop_w),
      .rsp_chan   (rsp_chan)
   );

endmodule

`default_nettype wire

// ===== hdl/sji_sine_rom.sv =====
// Constant sine table of one full turn with a registered read port.
`default_nettype none

module sji_sine_rom import sji_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic                                  clock,
   input  wire logic                                  read_en,
   input  wire logic [$clog2(SINE_TABLE_DEPTH)-1:0]   addr,
   output logic signed [SINE_W-1:0]                   data
);

   localparam logic [63:0] Q30_PI      = 64'd3373259426;
   localparam logic [63:0] Q30_TWO_PI  = 64'd6746518852;
   localparam logic [63:0] Q30_HALF_PI = 64'd1686629713;
   localparam logic [63:0] Q30_ONE     = 64'd1073741824;

   // Taylor series in Q30 on the angle folded into the first quadrant.
   function automatic logic signed [SINE_W-1:0] sine_entry(input logic [31:0] k);
      logic [63:0]        a;
      logic [63:0]        m;
      logic [63:0]        m2;
      logic [63:0]        term;
      logic [63:0]        mag;
      logic signed [63:0] acc;
      logic               neg;
      a   = (64'(k) * Q30_TWO_PI) / 64'(SINE_TABLE_DEPTH);
      m   = a;
      neg = 1'b0;
      if (a > Q30_PI) begin
         m   = Q30_TWO_PI - a;
         neg = 1'b1;
      end
      if (m > Q30_HALF_PI) begin
         m = Q30_PI - m;
      end
      m2   = (m * m) >> 30;
      term = m;
      acc  = $signed(m);
      term = ((term * m2) >> 30) / 64'd6;
      acc  = acc - $signed(term);
      term = ((term * m2) >> 30) / 64'd20;
      acc  = acc + $signed(term);
      term = ((term * m2) >> 30) / 64'd42;
      acc  = acc - $signed(term);
      term = ((term * m2) >> 30) / 64'd72;
      acc  = acc + $signed(term);
      term = ((term * m2) >> 30) / 64'd110;
      acc  = acc - $signed(term);
      term = ((term * m2) >> 30) / 64'd156;
      acc  = acc + $signed(term);
      if (acc < 0) begin
         acc = 64'sd0;
      end
      if (acc > $signed(Q30_ONE)) begin
         acc = $signed(Q30_ONE);
      end
      mag = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
      return neg ? -$signed(SINE_W'(mag)) : $signed(SINE_W'(mag));
   endfunction

   logic signed [SINE_W-1:0] lut_w [SINE_TABLE_DEPTH];
   logic signed [SINE_W-1:0] data_ff;

   for (genvar g = 0; g < SINE_TABLE_DEPTH; g++) begin : g_entry
      localparam logic signed [SINE_W-1:0] Entry = sine_entry(32'(g));
      assign lut_w[g] = Entry;
   end

   always_ff @(posedge clock) begin
      if (read_en) begin
         data_ff <= lut_w[addr];
      end
   end

   assign data = data_ff;

endmodule

`default_nettype wire

// ===== hdl/sji_front.sv =====
// Front part: accepts samples, looks up the sine, tracks the write position and builds jobs.
`default_nettype none

module sji_front import sji_pkg::*; #(
   parameter int SINE_TABLE_DEPTH = 1024
) (
   input  wire logic               clock,
   input  wire logic               reset,
   sji_req_if.sink                 req_chan,
   input  wire logic [PHASE_W-1:0] phase_increment,
   input  wire logic [AMP_W-1:0]   jitter_amplitude,
   input  wire logic               queue_ready,
   output logic                    job_push,
   output job_type                 job_data
);

   localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
   localparam int SCALE_W = PHASE_W + ADDR_W + 1;
   localparam int PROD_W  = AMP_W + SINE_W + 1;
   localparam int DISP_W  = PROD_W - 15;
   localparam int SUM_W   = FRAC_W + 3;

   logic                     advance_w;
   logic                     accept_w;
   logic [SCALE_W-1:0]       scaled_w;
   logic [ADDR_W-1:0]        rom_addr_w;
   logic signed [SINE_W-1:0] rom_data_w;

   logic [PHASE_W-1:0]       phase_ff, phase_in;
   logic                     s1_valid_ff, s1_bit_ff, s1_last_ff;
   logic                     s2_valid_ff, s2_bit_ff, s2_last_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic [FRAC_W-1:0]        frac_ff, frac_in;
   logic                     held_ff, held_in;

   logic [DISP_W-1:0]        disp_w;
   logic [SUM_W-1:0]         sum_w;
   logic [1:0]               adv_w;
   logic                     step_w;
   job_type                  job_w;

   // The whole pipeline moves only when the job queue has room.
   assign advance_w      = queue_ready;
   assign req_chan.ready = advance_w;
   assign accept_w       = req_chan.valid & advance_w;

   assign scaled_w   = SCALE_W'(phase_ff) * SCALE_W'(SINE_TABLE_DEPTH);
   assign rom_addr_w = scaled_w[PHASE_W +: ADDR_W];

   sji_sine_rom #(
      .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
   ) u_sine_rom (
      .clock   (clock),
      .read_en (accept_w),
      .addr    (rom_addr_w),
      .data    (rom_data_w)
   );

   assign phase_in = req_chan.end_of_track ? '0 : phase_ff + phase_increment;

   // Displacement is the product floored to Q.16; the step always stays in (0, 2).
   assign disp_w = prod_ff[PROD_W-1:15];
   assign sum_w  = {3'b001, frac_ff} + {{(SUM_W-DISP_W){disp_w[DISP_W-1]}}, disp_w};
   assign adv_w  = sum_w[FRAC_W +: 2];
   assign step_w = advance_w & s2_valid_ff;

   always_comb begin
      job_w.bits[0] = (adv_w != 2'd0) ? held_ff : s2_bit_ff;
      job_w.bits[1] = (adv_w == 2'd2) ? 1'b0 : s2_bit_ff;
      job_w.bits[2] = s2_bit_ff;
      job_w.count   = adv_w + {1'b0, s2_last_ff};
      job_w.last    = s2_last_ff;
      frac_in       = s2_last_ff ? '0 : sum_w[FRAC_W-1:0];
      held_in       = s2_last_ff ? 1'b0 : s2_bit_ff;
   end

   assign job_push = step_w & (job_w.count != 2'd0);
   assign job_data = job_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= '0;
         frac_ff     <= '0;
         held_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (accept_w) begin
            phase_ff <= phase_in;
         end
         if (advance_w) begin
            s1_valid_ff <= accept_w;
            s2_valid_ff <= s1_valid_ff;
         end
         if (step_w) begin
            frac_ff <= frac_in;
            held_ff <= held_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept_w) begin
         s1_bit_ff  <= req_chan.sample_bit;
         s1_last_ff <= req_chan.end_of_track;
      end
      if (advance_w) begin
         s2_bit_ff  <= s1_bit_ff;
         s2_last_ff <= s1_last_ff;
         prod_ff    <= $signed({1'b0, jitter_amplitude}) * rom_data_w;
      end
   end

   a_phase_clears_on_last: assert property (@(posedge clock) disable iff (reset)
      accept_w && req_chan.end_of_track |=> phase_ff == '0)
      else $error("phase accumulator not cleared after final sample");

   a_track_state_clears: assert property (@(posedge clock) disable iff (reset)
      step_w && s2_last_ff |=> frac_ff == '0 && !held_ff)
      else $error("position state not cleared after final sample");

   a_stall_freezes_phase: assert property (@(posedge clock) disable iff (reset)
      !advance_w |=> $stable(phase_ff))
      else $error("phase moved while the pipeline was stalled");

endmodule

`default_nettype wire

// ===== hdl/sji_queue.sv =====
// Short job queue between the front and back parts.
`default_nettype none

module sji_queue import sji_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_data,
   output logic         push_ready,
   input  wire logic    pop,
   output logic         head_valid,
   output job_type      head_data
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type           mem_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff, count_in;

   assign push_ready = count_ff != CNT_W'(QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_data  = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("job queue count beyond its depth");

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("job popped from an empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("job queue count did not follow a push");

endmodule

`default_nettype wire

// ===== hdl/sji_back.sv =====
// Back part: unpacks each job into output words through a registered output stage.
`default_nettype none

module sji_back import sji_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    head_valid,
   input  wire job_type head_data,
   output logic         pop,
   sji_rsp_if.source    rsp_chan
);

   logic       cur_valid_ff, cur_valid_in;
   logic [2:0] cur_bits_ff, cur_bits_in;
   logic [1:0] cur_left_ff, cur_left_in;
   logic       cur_last_ff, cur_last_in;
   logic       load_w;

   // A new job loads when the output is empty or its final word is taken.
   assign load_w = !cur_valid_ff || (rsp_chan.ready && cur_left_ff == 2'd1);
   assign pop    = load_w && head_valid;

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_bits_in  = cur_bits_ff;
      cur_left_in  = cur_left_ff;
      cur_last_in  = cur_last_ff;
      if (load_w) begin
         cur_valid_in = head_valid;
         cur_bits_in  = head_data.bits;
         cur_left_in  = head_data.count;
         cur_last_in  = head_data.last;
      end else if (rsp_chan.ready) begin
         cur_bits_in = {1'b0, cur_bits_ff[2:1]};
         cur_left_in = cur_left_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bits_ff <= cur_bits_in;
      cur_left_ff <= cur_left_in;
      cur_last_ff <= cur_last_in;
   end

   assign rsp_chan.valid    = cur_valid_ff;
   assign rsp_chan.out_bit  = cur_bits_ff[0];
   assign rsp_chan.out_last = cur_last_ff && cur_left_ff == 2'd1;

endmodule

`default_nettype wire
